// ===== rtl/biq_pkg.sv =====
// ============================================================================
// biq_pkg
// Shared sizes, codes and control types for the biquad IIR filter.
// ============================================================================
`default_nettype none

package biq_pkg;

   // Sizing
   localparam int NUM_SECTIONS  = 4;
   localparam int COEFS_PER_SEC = 5;
   localparam int NUM_COEFS     = NUM_SECTIONS * COEFS_PER_SEC;
   localparam int NUM_DLY       = NUM_SECTIONS * 2;
   localparam int SEC_W         = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
   localparam int COEF_AW       = $clog2(NUM_COEFS);
   localparam int DLY_AW        = (NUM_DLY > 1) ? $clog2(NUM_DLY) : 1;

   // Field and datapath widths
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 18;
   localparam int CIDX_W     = 5;
   localparam int DLY_W      = 24;
   localparam int PROD_W     = COEF_W + DLY_W;
   localparam int ACC_W      = 48;
   localparam int SCALE_SH   = 16;
   localparam int SECS_W     = 3;
   localparam int CSR_DATA_W = 3;
   localparam int CNT_W      = 8;

   // Round half up: bias of one half LSB at the 2^15 result scale
   localparam logic [ACC_W-1:0] ROUND_BIAS = {{(ACC_W-SCALE_SH){1'b0}}, 16'h8000};

   // Configuration register indexes
   localparam logic CSR_MODE     = 1'b0;
   localparam logic CSR_SECTIONS = 1'b1;

   // Item opcodes
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   // Coefficient position inside one section
   localparam logic [2:0] POS_A0 = 3'd0;
   localparam logic [2:0] POS_A1 = 3'd1;
   localparam logic [2:0] POS_A2 = 3'd2;
   localparam logic [2:0] POS_B1 = 3'd3;
   localparam logic [2:0] POS_B2 = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_W1,
      S_RD_W2,
      S_RD_A0,
      S_CALC_W,
      S_MUL_A0,
      S_MUL_A1,
      S_MUL_A2,
      S_ACC_Y,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_HOLD,
      MUL_DLY,
      MUL_W,
      MUL_W1,
      MUL_W2
   } mul_src_type;

   typedef struct packed {
      logic        init_sample;
      logic        init_zero;
      logic        sec_start;
      logic        from_y;
      logic        acc_sub;
      logic        calc_w;
      logic        yacc_add;
      logic        w1_load;
      logic        w2_load;
      mul_src_type mul_src;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/biquad_iir_filter.sv =====
// ============================================================================
// biquad_iir_filter
// Direct-form-II biquad cascade / parallel bank with coefficient and delay
// state held in synchronous memories and one shared multiply-accumulate.
// ============================================================================
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ---------------------------------------
//  req_     in   req_valid/req_stall  op, coef_index, coef_value, sample
//  rsp_     out  rsp_valid/rsp_stall  filtered, saturated
//  csr_     in   csr_valid/csr_ready  index (0 mode, 1 sections_in_use), wdata
//
//  Coefficient write item: accept, then result load from the final state.
//  Filter item: per active section RD_W1, RD_W2, RD_A0, CALC_W, MUL_A0, MUL_A1,
//  MUL_A2, ACC_Y, set by the one delay memory read port and single multiplier.
//  Reset: cascade mode, one section, delay store reads as zero (valid bits);
//  coefficient memory is not cleared and must be written before use.
//  Output stall: result holds in the output register; the next item is
//  accepted meanwhile and waits in its final state until the slot frees.
// ============================================================================
`default_nettype none

module biquad_iir_filter
   import biq_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_op,
   input  wire logic [CIDX_W-1:0]            req_coef_index,
   input  wire logic signed [COEF_W-1:0]     req_coef_value,
   input  wire logic signed [SAMPLE_W-1:0]   req_sample,

   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]        rsp_filtered,
   output logic                              rsp_saturated,

   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic              mode_ff;
   logic [SECS_W-1:0] sections_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         sections_ff <= SECS_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:     mode_ff     <= csr_wdata[0];
            CSR_SECTIONS: sections_ff <= csr_wdata[SECS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [SEC_W-1:0] sec_ff, sec_in;
   logic [SEC_W-1:0] last_sec_ff, last_sec_in;

   logic             rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff;
   logic             rsp_saturated_ff;
   logic             rsp_load;

   mac_ctrl_type     ctrl;
   logic [CNT_W-1:0] nsec;
   logic             req_accept;

   // Memory controls
   logic               coef_we;
   logic               coef_re;
   logic [2:0]         coef_pos;
   logic [COEF_AW-1:0] coef_base;
   logic [COEF_AW-1:0] coef_ra;
   logic [COEF_AW-1:0] coef_wa;
   logic               dly_re;
   logic               dly_odd_rd;
   logic               dly_we;
   logic               dly_odd_wr;
   logic [DLY_AW-1:0]  dly_ra;
   logic [DLY_AW-1:0]  dly_wa;
   logic signed [DLY_W-1:0] dly_wdata;

   logic signed [COEF_W-1:0] coef_rd_ff;
   logic signed [DLY_W-1:0]  dly_rd_ff;
   logic signed [DLY_W-1:0]  w_val;
   logic signed [DLY_W-1:0]  w1_val;
   logic signed [SAMPLE_W-1:0] mac_filtered;
   logic             mac_saturated;

   // Active section count, capped at the built section count
   assign nsec = ({{(CNT_W-SECS_W){1'b0}}, sections_ff} > NUM_SECTIONS)
               ? CNT_W'(NUM_SECTIONS) : {{(CNT_W-SECS_W){1'b0}}, sections_ff};

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Out-of-range coefficient indexes are dropped
   assign coef_wa = COEF_AW'(req_coef_index);

   always_comb begin
      state_in    = state_ff;
      sec_in      = sec_ff;
      last_sec_in = last_sec_ff;
      ctrl        = '0;
      ctrl.mul_src = MUL_HOLD;
      coef_we     = 1'b0;
      coef_re     = 1'b0;
      coef_pos    = POS_A0;
      dly_re      = 1'b0;
      dly_odd_rd  = 1'b0;
      dly_we      = 1'b0;
      dly_odd_wr  = 1'b0;
      rsp_load    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sec_in      = '0;
               last_sec_in = SEC_W'(nsec - CNT_W'(1));
               if (req_op == OP_COEF) begin
                  ctrl.init_zero = 1'b1;
                  coef_we        = (32'(req_coef_index) < NUM_COEFS);
                  state_in       = S_DONE;
               end else begin
                  ctrl.init_sample = 1'b1;
                  state_in = (nsec == '0) ? S_DONE : S_RD_W1;
               end
            end
         end
         // fetch w1 and b1
         S_RD_W1: begin
            ctrl.sec_start = 1'b1;
            ctrl.from_y    = !mode_ff && (sec_ff != '0);
            dly_re         = 1'b1;
            coef_re        = 1'b1;
            coef_pos       = POS_B1;
            state_in       = S_RD_W2;
         end
         // b1*w1; fetch w2 and b2
         S_RD_W2: begin
            ctrl.w1_load = 1'b1;
            ctrl.mul_src = MUL_DLY;
            dly_re       = 1'b1;
            dly_odd_rd   = 1'b1;
            coef_re      = 1'b1;
            coef_pos     = POS_B2;
            state_in     = S_RD_A0;
         end
         // b2*w2; fetch a0
         S_RD_A0: begin
            ctrl.w2_load = 1'b1;
            ctrl.mul_src = MUL_DLY;
            ctrl.acc_sub = 1'b1;
            coef_re      = 1'b1;
            coef_pos     = POS_A0;
            state_in     = S_CALC_W;
         end
         // w = sat(round(acc)); w2 <= w1 in the store
         S_CALC_W: begin
            ctrl.calc_w = 1'b1;
            dly_we      = 1'b1;
            dly_odd_wr  = 1'b1;
            state_in    = S_MUL_A0;
         end
         // a0*w; w1 <= w in the store
         S_MUL_A0: begin
            ctrl.mul_src = MUL_W;
            dly_we       = 1'b1;
            coef_re      = 1'b1;
            coef_pos     = POS_A1;
            state_in     = S_MUL_A1;
         end
         S_MUL_A1: begin
            ctrl.yacc_add = 1'b1;
            ctrl.mul_src  = MUL_W1;
            coef_re       = 1'b1;
            coef_pos      = POS_A2;
            state_in      = S_MUL_A2;
         end
         S_MUL_A2: begin
            ctrl.yacc_add = 1'b1;
            ctrl.mul_src  = MUL_W2;
            state_in      = S_ACC_Y;
         end
         S_ACC_Y: begin
            ctrl.yacc_add = 1'b1;
            if (sec_ff == last_sec_ff) begin
               state_in = S_DONE;
            end else begin
               sec_in   = sec_ff + 1'b1;
               state_in = S_RD_W1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      sec_ff      <= sec_in;
      last_sec_ff <= last_sec_in;
   end

   // ---------------------------------------------------------------------
   // Coefficient memory: written by op=1 items, read one entry a cycle
   // ---------------------------------------------------------------------
   logic signed [COEF_W-1:0] coef_mem [NUM_COEFS];

   assign coef_base = COEF_AW'({sec_ff, 2'b00}) + COEF_AW'(sec_ff);
   assign coef_ra   = coef_base + COEF_AW'(coef_pos);

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= req_coef_value;
      end
      if (coef_re) begin
         coef_rd_ff <= coef_mem[coef_ra];
      end
   end

   // ---------------------------------------------------------------------
   // Delay memory: w1 at even, w2 at odd address of each section.
   // Reads and writes of one section are sequenced apart, so no
   // forwarding path is needed. Unwritten entries read as zero.
   // ---------------------------------------------------------------------
   logic signed [DLY_W-1:0] dly_mem [NUM_DLY];
   logic [NUM_DLY-1:0]      dly_vld_ff;

   assign dly_ra    = DLY_AW'({sec_ff, dly_odd_rd});
   assign dly_wa    = DLY_AW'({sec_ff, dly_odd_wr});
   assign dly_wdata = dly_odd_wr ? w1_val : w_val;

   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_wa] <= dly_wdata;
      end
      if (dly_re) begin
         dly_rd_ff <= dly_vld_ff[dly_ra] ? dly_mem[dly_ra] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_vld_ff <= '0;
      end else if (dly_we) begin
         dly_vld_ff[dly_wa] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Arithmetic
   // ---------------------------------------------------------------------
   biq_mac u_mac (
      .clock     (clock),
      .ctrl      (ctrl),
      .mode      (mode_ff),
      .sample    (req_sample),
      .coef_rd   (coef_rd_ff),
      .dly_rd    (dly_rd_ff),
      .w_out     (w_val),
      .w1_out    (w1_val),
      .filtered  (mac_filtered),
      .saturated (mac_saturated)
   );

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_filtered_ff  <= mac_filtered;
         rsp_saturated_ff <= mac_saturated;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Delay store is never read and written at the same entry in one cycle
   a_dly_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(dly_we && dly_re && (dly_wa == dly_ra)))
      else $error("delay store read/write collision");

   // Section counter stays within the active count while busy
   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_DONE) |-> (sec_ff <= last_sec_ff))
      else $error("section counter past last active section");

   // Every accepted item leaves idle on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("accepted item did not start");

   // A result only appears from the final state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result loaded outside final state");

endmodule

`default_nettype wire

// ===== rtl/biq_mac.sv =====
// ============================================================================
// biq_mac
// Shared multiply-accumulate datapath: one 18x24 product per cycle,
// feedback and output accumulators, rounding and saturation.
// ============================================================================
`default_nettype none

module biq_mac
   import biq_pkg::*;
(
   input  wire logic                       clock,
   input  wire mac_ctrl_type               ctrl,
   input  wire logic                       mode,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic signed [COEF_W-1:0]   coef_rd,
   input  wire logic signed [DLY_W-1:0]    dly_rd,
   output logic signed [DLY_W-1:0]         w_out,
   output logic signed [DLY_W-1:0]         w1_out,
   output logic signed [SAMPLE_W-1:0]      filtered,
   output logic                            saturated
);

   localparam int T_W = ACC_W - SCALE_SH;
   localparam int W_MAX = (1 << (DLY_W-1)) - 1;
   localparam int W_MIN = -(1 << (DLY_W-1));
   localparam int S_MAX = (1 << (SAMPLE_W-1)) - 1;
   localparam int S_MIN = -(1 << (SAMPLE_W-1));

   // Scale 2^31 to 2^15 (bias already in the value), clip to 24 bits
   function automatic logic signed [DLY_W-1:0] round_sat24(input logic signed [ACC_W-1:0] v);
      logic signed [T_W-1:0] t;
      t = v[ACC_W-1:SCALE_SH];
      if (t > W_MAX) begin
         return DLY_W'(W_MAX);
      end else if (t < W_MIN) begin
         return DLY_W'(W_MIN);
      end
      return t[DLY_W-1:0];
   endfunction

   // {x, one half} at scale 2^31
   function automatic logic signed [ACC_W-1:0] with_bias(input logic signed [DLY_W-1:0] x);
      return {{(ACC_W-DLY_W-SCALE_SH){x[DLY_W-1]}}, x, 16'h8000};
   endfunction

   logic signed [DLY_W-1:0]  x_ff;
   logic signed [DLY_W-1:0]  w_ff;
   logic signed [DLY_W-1:0]  w1_ff;
   logic signed [DLY_W-1:0]  w2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  yacc_ff;

   logic signed [DLY_W-1:0]  sample_ext;
   logic signed [DLY_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  acc_diff;
   logic signed [T_W-1:0]    y_full;

   assign sample_ext = {{(DLY_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
   assign prod_ext   = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign acc_diff   = acc_ff - prod_ext;

   always_comb begin
      case (ctrl.mul_src)
         MUL_DLY: mul_b = dly_rd;
         MUL_W:   mul_b = w_ff;
         MUL_W1:  mul_b = w1_ff;
         MUL_W2:  mul_b = w2_ff;
         default: mul_b = '0;
      endcase
   end

   assign prod_in = coef_rd * mul_b;

   always_ff @(posedge clock) begin
      if (ctrl.init_sample) begin
         x_ff    <= sample_ext;
         yacc_ff <= mode ? ROUND_BIAS : with_bias(sample_ext);
      end
      if (ctrl.init_zero) begin
         yacc_ff <= '0;
      end
      if (ctrl.sec_start) begin
         acc_ff <= with_bias(ctrl.from_y ? round_sat24(yacc_ff) : x_ff);
         if (!mode) begin
            yacc_ff <= ROUND_BIAS;
         end
      end
      if (ctrl.acc_sub) begin
         acc_ff <= acc_diff;
      end
      if (ctrl.calc_w) begin
         w_ff <= round_sat24(acc_diff);
      end
      if (ctrl.yacc_add) begin
         yacc_ff <= yacc_ff + prod_ext;
      end
      if (ctrl.w1_load) begin
         w1_ff <= dly_rd;
      end
      if (ctrl.w2_load) begin
         w2_ff <= dly_rd;
      end
      if (ctrl.mul_src != MUL_HOLD) begin
         prod_ff <= prod_in;
      end
   end

   // Final output: one rounding, 16-bit clip with flag
   assign y_full = yacc_ff[ACC_W-1:SCALE_SH];

   always_comb begin
      saturated = 1'b1;
      if (y_full > S_MAX) begin
         filtered = SAMPLE_W'(S_MAX);
      end else if (y_full < S_MIN) begin
         filtered = SAMPLE_W'(S_MIN);
      end else begin
         filtered  = y_full[SAMPLE_W-1:0];
         saturated = 1'b0;
      end
   end

   assign w_out  = w_ff;
   assign w1_out = w1_ff;

endmodule

`default_nettype wire

// ===== verif/biquad_iir_filter_tb.sv =====
// ============================================================================
// biquad_iir_filter_tb
// Self-checking bench for the direct-form-II biquad cascade / parallel filter.
// A queue-fed driver sends coefficient writes and samples with random gaps.
// A monitor stalls the result side at random. A bit-true predictor of the
// section arithmetic supplies the expected output and clip flag per item.
// ============================================================================
module biquad_iir_filter_tb import biq_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // ------------------------------------------------------------------------
   // Bench constants
   // ------------------------------------------------------------------------
   localparam logic   MODE_CASCADE  = 1'b0;
   localparam logic   MODE_PARALLEL = 1'b1;
   localparam longint DLY_MAX       = 64'sd8388607;
   localparam longint DLY_MIN       = -64'sd8388608;
   localparam longint OUT_MAX       = 64'sd32767;
   localparam longint OUT_MIN       = -64'sd32768;
   localparam longint COEF_MAX      = 64'sd131071;
   localparam longint COEF_MIN      = -64'sd131072;
   localparam int     GAP_MAX       = 10;
   localparam int     DRAIN_CYCLES  = 40;       // longer than a 4-section item
   localparam int     RANDOM_ITEMS  = 800;
   localparam int     MAX_SHOWN     = 10;
   localparam int     TIMEOUT_NS    = 2_000_000;

   // Second-order Butterworth low-pass at fs/4, Q2.16 (b1 is zero)
   localparam longint BW_A0 = 19195;
   localparam longint BW_A1 = 38390;
   localparam longint BW_B2 = 11244;

   typedef enum int {SET_PRESET, SET_STABLE, SET_NOISE} coef_set_type;

   typedef struct {
      logic                       op;
      logic [CIDX_W-1:0]          coef_index;
      logic signed [COEF_W-1:0]   coef_value;
      logic signed [SAMPLE_W-1:0] sample;
   } filter_request_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       saturated;
   } filter_result_type;

   // ------------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic                       req_op         = OP_FILTER;
   logic [CIDX_W-1:0]          req_coef_index = '0;
   logic signed [COEF_W-1:0]   req_coef_value = '0;
   logic signed [SAMPLE_W-1:0] req_sample     = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic                       rsp_saturated;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic                       csr_index      = CSR_MODE;
   logic [CSR_DATA_W-1:0]      csr_wdata      = '0;

   biquad_iir_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_filtered   (rsp_filtered),
      .rsp_saturated  (rsp_saturated),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   filter_request_type pending_requests[$];   // filled by stimulus, drained by driver
   filter_result_type  expected_outputs[$];   // oldest prediction at the front

   // Predictor copy of the block state
   longint              coef_bank[NUM_COEFS];
   longint              dly_w1[NUM_SECTIONS];
   longint              dly_w2[NUM_SECTIONS];
   logic                pred_mode     = MODE_CASCADE;
   logic [SECS_W-1:0]   pred_sections = 3'd1;

   logic               idle_on = 1'b1;        // random gaps/stalls on for this phase
   int                 send_gap;
   int                 hold_cnt;
   int                 hold_next;
   filter_request_type next_req;
   filter_result_type  want;

   int mismatches      = 0;
   int results_checked = 0;
   int filter_items    = 0;
   int coef_writes     = 0;
   int saturated_seen  = 0;
   int stim_count      = 0;
   int phases_run      = 0;

   initial begin
      for (int i = 0; i < NUM_COEFS; i++) coef_bank[i] = 0;
      for (int i = 0; i < NUM_SECTIONS; i++) begin
         dly_w1[i] = 0;
         dly_w2[i] = 0;
      end
   end

   // ------------------------------------------------------------------------
   // Clock, reset, timeout
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("biquad_iir_filter test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   // Scale 2^31 -> 2^15, round half up (arithmetic shift floors)
   function automatic longint round_to_q15(longint acc);
      return (acc + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // One DF-II section; returns y at scale 2^31 and shifts the delay pair
   function automatic longint advance_section(int s, longint x);
      longint w1, w2, w;
      int     base;
      base = s * COEFS_PER_SEC;
      w1   = dly_w1[s];
      w2   = dly_w2[s];
      w    = clip(round_to_q15(x * 65536 - coef_bank[base + POS_B1] * w1
                               - coef_bank[base + POS_B2] * w2), DLY_MIN, DLY_MAX);
      dly_w2[s] = w1;
      dly_w1[s] = w;
      return coef_bank[base + POS_A0] * w + coef_bank[base + POS_A1] * w1
             + coef_bank[base + POS_A2] * w2;
   endfunction

   function automatic void predict_filter_output(logic op, logic [CIDX_W-1:0] idx,
                                                 logic signed [COEF_W-1:0] cval,
                                                 logic signed [SAMPLE_W-1:0] smp);
      filter_result_type res;
      longint            x, y, full, acc, clipped;
      int                n;
      res.filtered  = '0;
      res.saturated = 1'b0;
      if (op == OP_COEF) begin
         // out-of-range index is dropped; delays untouched
         if (idx < NUM_COEFS) coef_bank[idx] = cval;
         coef_writes++;
      end else begin
         n    = (pred_sections > NUM_SECTIONS) ? NUM_SECTIONS : pred_sections;
         x    = smp;
         full = x;                      // zero sections in cascade: pass-through
         acc  = 0;
         if (pred_mode == MODE_CASCADE) begin
            for (int s = 0; s < n; s++) begin
               y    = round_to_q15(advance_section(s, x));
               full = y;
               if (s + 1 < n) x = clip(y, DLY_MIN, DLY_MAX);
            end
         end else begin
            // parallel: exact sum, one rounding
            for (int s = 0; s < n; s++) acc += advance_section(s, x);
            full = round_to_q15(acc);
         end
         clipped       = clip(full, OUT_MIN, OUT_MAX);
         res.filtered  = SAMPLE_W'(clipped);
         res.saturated = (clipped != full);
         filter_items++;
         if (res.saturated) saturated_seen++;
      end
      expected_outputs.push_back(res);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: one item in flight on req_, random gap after each accepted item
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall)
            predict_filter_output(req_op, req_coef_index, req_coef_value, req_sample);
         // payload holds while stalled
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               next_req        = pending_requests.pop_front();
               req_op         <= next_req.op;
               req_coef_index <= next_req.coef_index;
               req_coef_value <= next_req.coef_value;
               req_sample     <= next_req.sample;
               req_valid      <= 1'b1;
               send_gap       <= idle_on ? $urandom_range(0, GAP_MAX) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each accepted result, then stalls a random count
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               if (mismatches < MAX_SHOWN)
                  $display("%0t: result %0d/%0b arrived with nothing expected",
                           $realtime, rsp_filtered, rsp_saturated);
               mismatches++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_filtered !== want.filtered || rsp_saturated !== want.saturated) begin
                  if (mismatches < MAX_SHOWN) begin
                     $display("%0t: result %0d mismatch", $realtime, results_checked);
                     $display("   filtered exp %0d got %0d, saturated exp %0b got %0b",
                              want.filtered, rsp_filtered, want.saturated, rsp_saturated);
                  end
                  mismatches++;
               end
               results_checked++;
            end
            hold_next = idle_on ? $urandom_range(0, GAP_MAX) : 0;
         end else begin
            hold_next = (hold_cnt != 0) ? hold_cnt - 1 : 0;
         end
         hold_cnt  <= hold_next;
         rsp_stall <= (hold_next != 0);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // sample field is ignored on coefficient writes: randomize it
   task automatic queue_coef_write(input int idx, input longint value);
      filter_request_type r;
      r.op         = OP_COEF;
      r.coef_index = CIDX_W'(idx);
      r.coef_value = COEF_W'(value);
      r.sample     = SAMPLE_W'($urandom());
      pending_requests.push_back(r);
      if (idx < NUM_COEFS) stim_count++;
   endtask

   // coefficient fields are ignored on filter items: randomize them
   task automatic queue_sample(input longint value);
      filter_request_type r;
      r.op         = OP_FILTER;
      r.coef_index = CIDX_W'($urandom());
      r.coef_value = COEF_W'($urandom());
      r.sample     = SAMPLE_W'(value);
      pending_requests.push_back(r);
      stim_count++;
   endtask

   function automatic longint random_sample();
      logic signed [SAMPLE_W-1:0] raw;
      raw = SAMPLE_W'($urandom());
      case ($urandom_range(0, 9))
         0:       case ($urandom_range(0, 3))
                     0: return OUT_MAX;
                     1: return OUT_MIN;
                     2: return 0;
                     default: return -1;
                  endcase
         1, 2, 3, 4: return raw;
         default: return longint'($urandom_range(0, 4096)) - 2048;
      endcase
   endfunction

   // Loads a0,a1,a2,b1,b2 of one section
   task automatic load_section(input int s, input coef_set_type kind);
      longint                   c[COEFS_PER_SEC];
      longint                   lim;
      logic signed [COEF_W-1:0] raw;
      case (kind)
         SET_PRESET: c = '{BW_A0, BW_A1, BW_A0, 0, BW_B2};
         SET_STABLE: begin
            // poles inside the stability triangle: |b2| < 1, |b1| < 1 + b2
            c[POS_B2] = longint'($urandom_range(0, 117964)) - 58982;
            lim       = ((65536 + c[POS_B2]) * 61) / 64;
            c[POS_B1] = longint'($urandom_range(0, 2 * lim)) - lim;
            c[POS_A0] = longint'($urandom_range(0, 65536)) - 32768;
            c[POS_A1] = longint'($urandom_range(0, 65536)) - 32768;
            c[POS_A2] = longint'($urandom_range(0, 65536)) - 32768;
         end
         default: begin
            for (int i = 0; i < COEFS_PER_SEC; i++) begin
               raw = COEF_W'($urandom());
               case ($urandom_range(0, 7))
                  0:       c[i] = COEF_MAX;
                  1:       c[i] = COEF_MIN;
                  default: c[i] = raw;
               endcase
            end
         end
      endcase
      for (int i = 0; i < COEFS_PER_SEC; i++)
         queue_coef_write(s * COEFS_PER_SEC + i, c[i]);
   endtask

   // Everything sent and answered, then the block's worst latency on top
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_outputs.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MODE) pred_mode = data[0];
      else                 pred_sections = data;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int                phase;
      int                n_samples;
      logic              new_mode;
      logic [SECS_W-1:0] secs;

      // Directed, reset settings (cascade, one section). Section 0 gets the
      // Butterworth set; full-scale steps make the overshoot clip.
      load_section(0, SET_PRESET);
      queue_coef_write(31, COEF_MIN);           // out-of-range index: no effect
      queue_coef_write(NUM_COEFS, COEF_MAX);    // first index past the store
      repeat (4) queue_sample(OUT_MAX);
      repeat (4) queue_sample(OUT_MIN);
      queue_sample(0);
      queue_sample(1);
      queue_sample(-1);
      queue_sample(OUT_MIN);
      queue_sample(OUT_MAX);
      stim_count = 0;

      // Random phases. The first six force the register extremes: both modes
      // with 4, 0 and 7 (above the section count) active sections.
      for (phase = 0; stim_count < RANDOM_ITEMS || phase < 6; phase++) begin
         wait_idle();
         if (phase < 6) begin
            new_mode = phase[0] ? MODE_PARALLEL : MODE_CASCADE;
            case (phase / 2)
               0:       secs = 3'd4;
               1:       secs = 3'd0;
               default: secs = 3'd7;
            endcase
         end else begin
            new_mode = $urandom_range(0, 1) ? MODE_PARALLEL : MODE_CASCADE;
            secs     = ($urandom_range(0, 9) < 7) ? SECS_W'($urandom_range(1, NUM_SECTIONS))
                                                  : SECS_W'($urandom_range(0, 7));
         end
         // mode uses bit 0 only; upper data bits are don't-care
         write_csr(CSR_MODE, {2'($urandom()), new_mode});
         write_csr(CSR_SECTIONS, secs);
         phases_run++;
         idle_on = ($urandom_range(0, 3) != 0);

         // First phase loads every section before any sample reads them
         if (phase == 0 || $urandom_range(0, 2) == 0) begin
            for (int s = 0; s < NUM_SECTIONS; s++)
               load_section(s, ($urandom_range(0, 4) == 0) ? SET_NOISE : SET_STABLE);
         end else begin
            repeat ($urandom_range(1, 2))
               load_section($urandom_range(0, NUM_SECTIONS - 1), SET_STABLE);
         end

         n_samples = $urandom_range(20, 60);
         repeat (n_samples) begin
            // occasional stray writes between samples, some out of range
            if ($urandom_range(0, 19) == 0)
               queue_coef_write($urandom_range(NUM_COEFS, 31), longint'($urandom()));
            else if ($urandom_range(0, 29) == 0)
               queue_coef_write($urandom_range(0, NUM_COEFS - 1),
                                longint'($urandom_range(0, 131072)) - 65536);
            queue_sample(random_sample());
         end
      end

      wait_idle();
      $display("Ran %0d filter items and %0d coefficient writes over %0d register settings;",
               filter_items, coef_writes, phases_run);
      $display("%0d results compared, %0d of them clipped at the output.",
               results_checked, saturated_seen);
      if (mismatches == 0 && expected_outputs.size() == 0)
         $display("biquad_iir_filter test passed");
      else
         $display("biquad_iir_filter test failed");
      $finish;
   end

endmodule
